// ===== design/mtu_pkg.sv =====
package mtu_pkg;

    localparam int TABLE_WORDS  = 624;
    localparam int TAP_OFFSET   = 397;
    localparam int IDX_W        = 10;
    localparam int WORD_W       = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QCNT_W       = 2;

    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;

    typedef enum logic [1:0] {
        OP_SEED  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_DRAW  = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] val;
    } t_cmd;

    typedef struct packed {
        logic regen;
        logic resp;
    } t_stat;

endpackage

// ===== design/mtu_front.sv =====
module mtu_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_kind,
    input  logic [mtu_pkg::IDX_W-1:0]  i_seed_index,
    input  logic [mtu_pkg::WORD_W-1:0] i_seed_value,
    output logic                       o_cmd_valid,
    output mtu_pkg::t_cmd              o_cmd,
    input  logic                       i_cmd_ready
);
    import mtu_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    t_cmd              push_cmd;
    logic              push;
    logic              pop;

    // classify the incoming transfer
    always_comb begin
        push_cmd.idx = i_seed_index;
        push_cmd.val = i_seed_value;
        if (i_kind) begin
            push_cmd.op = OP_DRAW;
        end else if (i_seed_index < IDX_W'(TABLE_WORDS)) begin
            push_cmd.op = OP_SEED;
        end else begin
            push_cmd.op = OP_CLEAR;
        end
    end

    assign o_ready     = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/mtu_back.sv =====
module mtu_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  mtu_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_ready,
    output logic                       o_out_valid,
    output logic [mtu_pkg::WORD_W-1:0] o_out_word,
    input  logic                       i_out_ready,
    output mtu_pkg::t_stat             o_stat
);
    import mtu_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PRIME = 4'b0010,
        ST_TWIST = 4'b0100,
        ST_RESP  = 4'b1000
    } t_state;

    logic [WORD_W-1:0] r_mem [TABLE_WORDS];
    logic [WORD_W-1:0] r_rd_a;
    logic [WORD_W-1:0] r_rd_b;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_pos, n_pos;
    logic [IDX_W-1:0]  r_ii, n_ii;
    logic              r_cv, n_cv;
    logic [IDX_W-1:0]  r_ci, n_ci;
    logic [WORD_W-1:0] r_cur, n_cur;
    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_out_word, n_out_word;

    logic              rd_en_a, rd_en_b, wr_en;
    logic [IDX_W-1:0]  rd_addr_a, wr_addr;
    logic [IDX_W-1:0]  nxt_addr, tap_addr;
    logic [IDX_W:0]    tap_sum;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] mix_t;
    logic [WORD_W-1:0] twisted;

    assign nxt_addr = (r_ii == IDX_W'(TABLE_WORDS - 1)) ? '0 : r_ii + 1'b1;
    assign tap_sum  = {1'b0, r_ii} + (IDX_W+1)'(TAP_OFFSET);
    assign tap_addr = (tap_sum >= (IDX_W+1)'(TABLE_WORDS))
                    ? IDX_W'(tap_sum - (IDX_W+1)'(TABLE_WORDS)) : tap_sum[IDX_W-1:0];

    // upper bit of word i joined to lower bits of word i+1
    assign mix_t   = {r_cur[WORD_W-1], r_rd_a[WORD_W-2:0]};
    assign twisted = r_rd_b ^ (mix_t >> 1) ^ (mix_t[0] ? TWIST_MATRIX : '0);

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_ii        = r_ii;
        n_cv        = 1'b0;
        n_ci        = r_ci;
        n_cur       = r_cur;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        rd_en_a     = 1'b0;
        rd_addr_a   = r_pos;
        rd_en_b     = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = i_cmd.idx;
        wr_data     = i_cmd.val;
        o_cmd_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    case (i_cmd.op)
                        OP_SEED: begin
                            wr_en = 1'b1;
                            n_pos = '0;
                        end
                        OP_CLEAR: begin
                            n_pos = '0;
                        end
                        OP_DRAW: begin
                            if (r_pos >= IDX_W'(TABLE_WORDS)) begin
                                n_state = ST_PRIME;
                            end else begin
                                rd_en_a = 1'b1;
                                n_state = ST_RESP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_PRIME: begin
                rd_en_a   = 1'b1;
                rd_addr_a = '0;
                n_ii      = '0;
                n_state   = ST_TWIST;
            end
            ST_TWIST: begin
                if (r_cv) begin
                    wr_en   = 1'b1;
                    wr_addr = r_ci;
                    wr_data = twisted;
                end
                if (r_cv || r_ii == '0) begin
                    n_cur = r_rd_a;
                end
                if (r_ii != IDX_W'(TABLE_WORDS)) begin
                    rd_en_a   = 1'b1;
                    rd_addr_a = nxt_addr;
                    rd_en_b   = 1'b1;
                    n_ii      = r_ii + 1'b1;
                    n_cv      = 1'b1;
                    n_ci      = r_ii;
                end else if (!r_cv) begin
                    n_pos     = '0;
                    rd_en_a   = 1'b1;
                    rd_addr_a = '0;
                    n_state   = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_word  = r_rd_a;
                    n_pos       = r_pos + 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en_a) begin
            r_rd_a <= r_mem[rd_addr_a];
        end
        if (rd_en_b) begin
            r_rd_b <= r_mem[tap_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ci       <= n_ci;
        r_cur      <= n_cur;
        r_out_word <= n_out_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_ii        <= '0;
            r_cv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_ii        <= n_ii;
            r_cv        <= n_cv;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign o_stat.regen = (r_state == ST_PRIME) || (r_state == ST_TWIST);
    assign o_stat.resp  = (r_state == ST_RESP);

endmodule

// ===== design/mersenne_twister_untempered.sv =====
// untempered mersenne twister word generator (mt19937 recurrence)
// input channel i_valid/o_ready carries i_kind, i_seed_index, i_seed_value:
//   kind 0 stores a seed word and rewinds the read position, no result;
//   an index of 624 or more stores nothing but still rewinds
//   kind 1 draws one word, returned on o_valid/i_ready as o_random_word
// input transfers land in a two-entry command queue; the engine behind it
// owns the 624-word table in a memory with two registered read ports
// a seed is a single table write; a draw reads the table, then loads the
// output register; a draw that finds all 624 words used first regenerates
// the table, one word per cycle, paced by its read-twist-write memory loop
// the output register lets the queue keep filling while a result waits;
// if the receiver stalls, the engine holds the next draw until it is free
// reset clears the read position, queue and output valid; the table is
// undefined until seeded; the user must seed all 624 words before the
// first draw, and the block itself does not enforce it
module mersenne_twister_untempered (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_kind,
    input  logic [mtu_pkg::IDX_W-1:0]  i_seed_index,
    input  logic [mtu_pkg::WORD_W-1:0] i_seed_value,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [mtu_pkg::WORD_W-1:0] o_random_word
);
    import mtu_pkg::*;

    t_cmd  cmd;
    logic  cmd_valid;
    logic  cmd_ready;
    t_stat stat;

    mtu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_seed_index (i_seed_index),
        .i_seed_value (i_seed_value),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_ready  (cmd_ready)
    );

    mtu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ready (cmd_ready),
        .o_out_valid (o_valid),
        .o_out_word  (o_random_word),
        .i_out_ready (i_ready),
        .o_stat      (stat)
    );

`ifndef SYNTHESIS
    a_no_pop_in_regen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.regen |-> !(cmd_valid && cmd_ready))
        else $error("command taken during table regeneration");

    a_result_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(stat.resp))
        else $error("result raised outside the response step");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> cmd_valid)
        else $error("accepted transfer missing from command queue");
`endif

endmodule

// ===== tb/mersenne_twister_untempered_checker.sv =====
module mersenne_twister_untempered_checker #(
    parameter bit DRAW_KIND = 1'b1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       in_kind,
    input  logic [mtu_pkg::IDX_W-1:0]  in_seed_index,
    input  logic [mtu_pkg::WORD_W-1:0] in_seed_value,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [mtu_pkg::WORD_W-1:0] out_random_word,
    output int                         error_count,
    output int                         words_pending,
    output int                         draws_checked,
    output int                         table_passes,
    output int                         seeds_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import mtu_pkg::*;

    logic [WORD_W-1:0] state_words [TABLE_WORDS];
    int unsigned       draw_position;
    logic [WORD_W-1:0] upcoming_words [$];

    initial begin
        error_count   = 0;
        words_pending = 0;
        draws_checked = 0;
        table_passes  = 0;
        seeds_seen    = 0;
        draw_position = 0;
        foreach (state_words[i]) state_words[i] = '0;
    end

    // in-place regeneration, words already replaced this pass feed later ones
    function automatic void twist_state_words();
        logic [WORD_W-1:0] joined;
        for (int i = 0; i < TABLE_WORDS; i++) begin
            joined = {state_words[i][WORD_W-1], state_words[(i + 1) % TABLE_WORDS][WORD_W-2:0]};
            state_words[i] = state_words[(i + TAP_OFFSET) % TABLE_WORDS] ^ (joined >> 1)
                             ^ (joined[0] ? TWIST_MATRIX : '0);
        end
    endfunction

    function automatic logic [WORD_W-1:0] next_untempered_word();
        logic [WORD_W-1:0] word;
        if (draw_position >= TABLE_WORDS) begin
            twist_state_words();
            table_passes++;
            draw_position = 0;
        end
        word = state_words[draw_position];
        draw_position = (draw_position + 1) % (1 << IDX_W);
        return word;
    endfunction

    always @(posedge clk) begin
        logic [WORD_W-1:0] want;
        if (!rst_n) begin
            draw_position = 0;
            upcoming_words.delete();
        end else begin
            if (in_valid && in_ready) begin
                if (in_kind == DRAW_KIND) begin
                    upcoming_words.push_back(next_untempered_word());
                end else begin
                    if (in_seed_index < TABLE_WORDS) state_words[in_seed_index] = in_seed_value;
                    draw_position = 0;
                    seeds_seen++;
                end
            end
            if (out_valid && out_ready) begin
                if (upcoming_words.size() == 0) begin
                    $error("random_word: expected none, actual %h", out_random_word);
                    error_count++;
                end else begin
                    want = upcoming_words.pop_front();
                    draws_checked++;
                    if (out_random_word !== want) begin
                        $error("random_word: expected %h, actual %h", want, out_random_word);
                        error_count++;
                    end
                end
            end
        end
        words_pending = upcoming_words.size();
    end

endmodule

// ===== tb/mersenne_twister_untempered_tb.sv =====
module mersenne_twister_untempered_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mtu_pkg::*;

    localparam bit KIND_SEED      = 1'b0;
    localparam bit KIND_DRAW      = 1'b1;
    localparam int LONG_RUN_DRAWS = 660;
    localparam int MIXED_ITEMS    = 120;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 40;
    localparam int CYCLE_LIMIT    = 400000;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              i_valid      = 1'b0;
    logic              i_kind       = KIND_SEED;
    logic [IDX_W-1:0]  i_seed_index = '0;
    logic [WORD_W-1:0] i_seed_value = '0;
    logic              i_ready      = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic [WORD_W-1:0] o_random_word;

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;
    int cycles   = 0;
    int error_count, words_pending, draws_checked, table_passes, seeds_seen;

    mersenne_twister_untempered dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_seed_index  (i_seed_index),
        .i_seed_value  (i_seed_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_random_word (o_random_word)
    );

    mersenne_twister_untempered_checker #(
        .DRAW_KIND (KIND_DRAW)
    ) checker_i (
        .clk             (i_clk),
        .rst_n           (i_rst_n),
        .in_valid        (i_valid),
        .in_ready        (o_ready),
        .in_kind         (i_kind),
        .in_seed_index   (i_seed_index),
        .in_seed_value   (i_seed_value),
        .out_valid       (o_valid),
        .out_ready       (i_ready),
        .out_random_word (o_random_word),
        .error_count     (error_count),
        .words_pending   (words_pending),
        .draws_checked   (draws_checked),
        .table_passes    (table_passes),
        .seeds_seen      (seeds_seen)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[mersenne_twister_untempered] ERROR");
                $finish;
            end
        end
    end

    // receiver side, with one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            i_ready <= !i_rst_n ? 1'b0 : (!idle_on || $urandom_range(99) >= 21);
        end
    end

    // call at a rising edge; returns at the edge of the transfer
    task automatic send_item(input bit kind, input logic [IDX_W-1:0] idx,
                             input logic [WORD_W-1:0] val);
        while (idle_on && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_seed_index <= idx;
        i_seed_value <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_draw();
        send_item(KIND_DRAW, IDX_W'($urandom_range(1023)), $urandom);
    endtask

    task automatic wait_all_words();
        i_valid <= 1'b0;
        @(negedge i_clk);
        wait (words_pending == 0);
    endtask

    initial begin
        logic [WORD_W-1:0] seed_word;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the whole table, extremes at the ends
        for (int i = 0; i < TABLE_WORDS; i++) begin
            case (i)
                0:           seed_word = 32'hFFFF_FFFF;
                1:           seed_word = 32'h8000_0000;
                2:           seed_word = 32'h7FFF_FFFF;
                3:           seed_word = 32'h0000_0001;
                TABLE_WORDS - 1: seed_word = 32'h0000_0000;
                default:     seed_word = $urandom;
            endcase
            send_item(KIND_SEED, IDX_W'(i), seed_word);
        end

        // seed words come back untouched, out-of-range seeds only rewind
        repeat (4) send_draw();
        send_item(KIND_SEED, IDX_W'(TABLE_WORDS), 32'hFFFF_FFFF);
        send_draw();
        send_item(KIND_SEED, 10'h3FF, 32'h0000_0000);
        send_draw();
        send_draw();
        send_item(KIND_SEED, 10'd0, 32'h0000_0000);
        send_draw();
        send_item(KIND_SEED, IDX_W'(TABLE_WORDS - 1), 32'hFFFF_FFFF);
        send_draw();
        send_item(KIND_SEED, 10'd1, 32'h5555_AAAA);
        send_draw();
        send_draw();

        // one long run of draws through a full table pass and the regeneration
        idle_on = 1'b0;
        for (int n = 0; n < LONG_RUN_DRAWS; n++) begin
            if (n == 200) idle_on = 1'b1;
            if (n == 300) hold_req = 1'b1;
            send_draw();
        end

        wait_all_words();
        @(posedge i_clk);

        for (int n = 0; n < MIXED_ITEMS; n++) begin
            if ($urandom_range(99) < 15)
                send_item(KIND_SEED, IDX_W'($urandom_range(1023)), $urandom);
            else
                send_draw();
        end

        wait_all_words();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d seed transfers and %0d checked draws", seeds_seen, draws_checked);
        $display("table regenerations seen: %0d", table_passes);
        if (error_count == 0) begin
            $display("[mersenne_twister_untempered] OK");
        end else begin
            $display("[mersenne_twister_untempered] ERROR");
        end
        $finish;
    end

endmodule
